// ===== rtl/sm83_pkg.sv =====
// ============================================================================
// sm83_pkg: shared types, constants and microcode for the 8-bit core
// Holds the control word layout, the microcode store, the opcode decode
// table and the architectural state record used by the datapath and top.
// ============================================================================
package sm83_pkg;

   localparam int ADDR_BITS_DEF = 16;
   localparam int UPC_BITS      = 5;

   // Item kinds on the request channel.
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_EXEC  = 2'd2;

   // Run status codes.
   localparam logic [1:0] RUN_OK   = 2'd0;
   localparam logic [1:0] RUN_HALT = 2'd1;
   localparam logic [1:0] RUN_BAD  = 2'd2;

   // Flag bit positions.
   localparam int FLAG_Z_BIT = 3;
   localparam int FLAG_N_BIT = 2;
   localparam int FLAG_H_BIT = 1;
   localparam int FLAG_C_BIT = 0;

   // Instruction opcodes.
   localparam logic [7:0] OPC_JR       = 8'h18;
   localparam logic [7:0] OPC_JR_NZ    = 8'h20;
   localparam logic [7:0] OPC_JR_Z     = 8'h28;
   localparam logic [7:0] OPC_JR_NC    = 8'h30;
   localparam logic [7:0] OPC_JR_C     = 8'h38;
   localparam logic [7:0] OPC_LD_BC    = 8'h01;
   localparam logic [7:0] OPC_LD_DE    = 8'h11;
   localparam logic [7:0] OPC_LD_HL    = 8'h21;
   localparam logic [7:0] OPC_LD_SP    = 8'h31;
   localparam logic [7:0] OPC_XOR_B    = 8'hA8;
   localparam logic [7:0] OPC_XOR_L    = 8'hAD;
   localparam logic [7:0] OPC_XOR_M    = 8'hAE;
   localparam logic [7:0] OPC_XOR_A    = 8'hAF;
   localparam logic [7:0] OPC_ST_BC    = 8'h02;
   localparam logic [7:0] OPC_ST_DE    = 8'h12;
   localparam logic [7:0] OPC_ST_HLI   = 8'h22;
   localparam logic [7:0] OPC_ST_HLD   = 8'h32;
   localparam logic [7:0] OPC_LD_B_D8  = 8'h06;
   localparam logic [7:0] OPC_LD_C_D8  = 8'h0E;
   localparam logic [7:0] OPC_LD_D_D8  = 8'h16;
   localparam logic [7:0] OPC_LD_E_D8  = 8'h1E;
   localparam logic [7:0] OPC_LD_H_D8  = 8'h26;
   localparam logic [7:0] OPC_LD_L_D8  = 8'h2E;
   localparam logic [7:0] OPC_LD_A_D8  = 8'h3E;
   localparam logic [7:0] OPC_LD_M_D8  = 8'h36;
   localparam logic [7:0] OPC_PREFIX   = 8'hCB;
   localparam logic [7:0] OPC_HALT     = 8'h76;
   localparam logic [7:0] CB_BIT_FIRST = 8'h40;
   localparam logic [7:0] CB_BIT_LAST  = 8'h7F;
   localparam logic [2:0] SRC_MEM      = 3'd6;

   // Microcode addresses. Routines that step with SEQ_NEXT are contiguous.
   localparam logic [UPC_BITS-1:0] U_IDLE    = 5'd0;
   localparam logic [UPC_BITS-1:0] U_WR      = 5'd1;
   localparam logic [UPC_BITS-1:0] U_RD      = 5'd2;
   localparam logic [UPC_BITS-1:0] U_RD2     = 5'd3;
   localparam logic [UPC_BITS-1:0] U_FETCH   = 5'd4;
   localparam logic [UPC_BITS-1:0] U_DECODE  = 5'd5;
   localparam logic [UPC_BITS-1:0] U_JR      = 5'd6;
   localparam logic [UPC_BITS-1:0] U_JR2     = 5'd7;
   localparam logic [UPC_BITS-1:0] U_LD16    = 5'd8;
   localparam logic [UPC_BITS-1:0] U_LD16B   = 5'd9;
   localparam logic [UPC_BITS-1:0] U_LD16C   = 5'd10;
   localparam logic [UPC_BITS-1:0] U_XOR_R   = 5'd11;
   localparam logic [UPC_BITS-1:0] U_XOR_M   = 5'd12;
   localparam logic [UPC_BITS-1:0] U_XOR_M2  = 5'd13;
   localparam logic [UPC_BITS-1:0] U_ST_BC   = 5'd14;
   localparam logic [UPC_BITS-1:0] U_ST_DE   = 5'd15;
   localparam logic [UPC_BITS-1:0] U_ST_HLI  = 5'd16;
   localparam logic [UPC_BITS-1:0] U_ST_HLD  = 5'd17;
   localparam logic [UPC_BITS-1:0] U_LD8     = 5'd18;
   localparam logic [UPC_BITS-1:0] U_LD8B    = 5'd19;
   localparam logic [UPC_BITS-1:0] U_LDM     = 5'd20;
   localparam logic [UPC_BITS-1:0] U_LDM2    = 5'd21;
   localparam logic [UPC_BITS-1:0] U_CB      = 5'd22;
   localparam logic [UPC_BITS-1:0] U_CB2     = 5'd23;
   localparam logic [UPC_BITS-1:0] U_CB_REG  = 5'd24;
   localparam logic [UPC_BITS-1:0] U_CB_MEM  = 5'd25;
   localparam logic [UPC_BITS-1:0] U_CB_MEM2 = 5'd26;
   localparam logic [UPC_BITS-1:0] U_HALT    = 5'd27;
   localparam logic [UPC_BITS-1:0] U_BAD     = 5'd28;
   localparam logic [UPC_BITS-1:0] U_DONE    = 5'd29;

   typedef enum logic [2:0] {
      ASEL_PC, ASEL_HL, ASEL_BC, ASEL_DE, ASEL_ITEM
   } addr_sel_type;

   typedef enum logic [1:0] {
      WSEL_ACC, WSEL_ITEM, WSEL_RDATA
   } wsel_type;

   typedef enum logic [3:0] {
      DP_NONE, DP_LATCH_OP, DP_LATCH_CB, DP_LATCH_LO, DP_LD_PAIR, DP_XOR,
      DP_LD_R8, DP_BIT, DP_JR, DP_HL_INC, DP_HL_DEC, DP_HALT, DP_BAD, DP_READ
   } dp_op_type;

   typedef enum logic [2:0] {
      CYC_0, CYC_4, CYC_8, CYC_12, CYC_16, CYC_JR
   } cyc_type;

   typedef enum logic [2:0] {
      SEQ_NEXT, SEQ_JUMP, SEQ_DECODE, SEQ_CBSEL, SEQ_IDLE, SEQ_DONE
   } seq_op_type;

   typedef struct packed {
      addr_sel_type          asel;
      logic                  mem_en;
      logic                  mem_we;
      wsel_type              wsel;
      logic                  pc_inc;
      dp_op_type             op;
      cyc_type               cyc;
      seq_op_type            seq;
      logic [UPC_BITS-1:0]   target;
   } ucw_type;

   typedef struct packed {
      ucw_type uw;
      logic    start;
      logic    load;
   } seq_ctrl_type;

   typedef struct packed {
      logic [1:0]  run_state;
      logic [7:0]  read_byte;
      logic [15:0] pc_value;
      logic [7:0]  acc_value;
      logic [3:0]  flag_value;
      logic [15:0] bc_value;
      logic [15:0] de_value;
      logic [15:0] hl_value;
      logic [15:0] sp_value;
      logic [31:0] cycle_value;
   } arch_type;

   localparam ucw_type UCW_NOP = '{
      asel:   ASEL_PC,
      mem_en: 1'b0,
      mem_we: 1'b0,
      wsel:   WSEL_ACC,
      pc_inc: 1'b0,
      op:     DP_NONE,
      cyc:    CYC_0,
      seq:    SEQ_NEXT,
      target: U_IDLE
   };

   // Microcode store: one control word per step.
   function automatic ucw_type ucode(input logic [UPC_BITS-1:0] upc);
      ucw_type w;
      w = UCW_NOP;
      case (upc)
         U_IDLE: begin
            w.seq = SEQ_IDLE;
         end
         U_WR: begin
            w.asel = ASEL_ITEM; w.mem_en = 1'b1; w.mem_we = 1'b1;
            w.wsel = WSEL_ITEM; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_RD: begin
            w.asel = ASEL_ITEM; w.mem_en = 1'b1;
         end
         U_RD2: begin
            w.op = DP_READ; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_FETCH, U_JR, U_LD16, U_LD8, U_LDM, U_CB: begin
            w.asel = ASEL_PC; w.mem_en = 1'b1; w.pc_inc = 1'b1;
         end
         U_DECODE: begin
            w.op = DP_LATCH_OP; w.seq = SEQ_DECODE;
         end
         U_JR2: begin
            w.op = DP_JR; w.cyc = CYC_JR; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_LD16B: begin
            w.asel = ASEL_PC; w.mem_en = 1'b1; w.pc_inc = 1'b1; w.op = DP_LATCH_LO;
         end
         U_LD16C: begin
            w.op = DP_LD_PAIR; w.cyc = CYC_12; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_XOR_R: begin
            w.op = DP_XOR; w.cyc = CYC_4; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_XOR_M, U_CB_MEM: begin
            w.asel = ASEL_HL; w.mem_en = 1'b1;
         end
         U_XOR_M2: begin
            w.op = DP_XOR; w.cyc = CYC_8; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_ST_BC: begin
            w.asel = ASEL_BC; w.mem_en = 1'b1; w.mem_we = 1'b1;
            w.cyc = CYC_8; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_ST_DE: begin
            w.asel = ASEL_DE; w.mem_en = 1'b1; w.mem_we = 1'b1;
            w.cyc = CYC_8; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_ST_HLI: begin
            w.asel = ASEL_HL; w.mem_en = 1'b1; w.mem_we = 1'b1; w.op = DP_HL_INC;
            w.cyc = CYC_8; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_ST_HLD: begin
            w.asel = ASEL_HL; w.mem_en = 1'b1; w.mem_we = 1'b1; w.op = DP_HL_DEC;
            w.cyc = CYC_8; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_LD8B: begin
            w.op = DP_LD_R8; w.cyc = CYC_8; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_LDM2: begin
            w.asel = ASEL_HL; w.mem_en = 1'b1; w.mem_we = 1'b1; w.wsel = WSEL_RDATA;
            w.cyc = CYC_12; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_CB2: begin
            w.op = DP_LATCH_CB; w.cyc = CYC_8; w.seq = SEQ_CBSEL;
         end
         U_CB_REG: begin
            w.op = DP_BIT; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_CB_MEM2: begin
            w.op = DP_BIT; w.cyc = CYC_8; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_HALT: begin
            w.op = DP_HALT; w.cyc = CYC_4; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_BAD: begin
            w.op = DP_BAD; w.seq = SEQ_JUMP; w.target = U_DONE;
         end
         U_DONE: begin
            w.seq = SEQ_DONE;
         end
         default: begin
            w.seq = SEQ_JUMP; w.target = U_IDLE;
         end
      endcase
      return w;
   endfunction

   // Dispatch table: first microcode step of each instruction.
   function automatic logic [UPC_BITS-1:0] decode_op(input logic [7:0] opc);
      logic [UPC_BITS-1:0] entry;
      case (opc) inside
         OPC_JR, OPC_JR_NZ, OPC_JR_Z, OPC_JR_NC, OPC_JR_C:
            entry = U_JR;
         OPC_LD_BC, OPC_LD_DE, OPC_LD_HL, OPC_LD_SP:
            entry = U_LD16;
         [OPC_XOR_B:OPC_XOR_L], OPC_XOR_A:
            entry = U_XOR_R;
         OPC_XOR_M:  entry = U_XOR_M;
         OPC_ST_BC:  entry = U_ST_BC;
         OPC_ST_DE:  entry = U_ST_DE;
         OPC_ST_HLI: entry = U_ST_HLI;
         OPC_ST_HLD: entry = U_ST_HLD;
         OPC_LD_B_D8, OPC_LD_C_D8, OPC_LD_D_D8, OPC_LD_E_D8,
         OPC_LD_H_D8, OPC_LD_L_D8, OPC_LD_A_D8:
            entry = U_LD8;
         OPC_LD_M_D8: entry = U_LDM;
         OPC_PREFIX:  entry = U_CB;
         OPC_HALT:    entry = U_HALT;
         default:     entry = U_BAD;
      endcase
      return entry;
   endfunction

   // Branch after the prefixed byte: BIT on a register, BIT on memory, or done.
   function automatic logic [UPC_BITS-1:0] cb_entry(input logic [7:0] code);
      logic [UPC_BITS-1:0] entry;
      if (code inside {[CB_BIT_FIRST:CB_BIT_LAST]}) begin
         entry = (code[2:0] == SRC_MEM) ? U_CB_MEM : U_CB_REG;
      end else begin
         entry = U_DONE;
      end
      return entry;
   endfunction

endpackage

// ===== rtl/sm83_if.sv =====
// ============================================================================
// sm83 channel interfaces
// Valid/ready channels for request items and result items.
// ============================================================================
interface sm83_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] mem_address;
   logic [7:0]  mem_data;

   modport source (output valid, output opcode, output mem_address,
                   output mem_data, input ready);
   modport sink   (input valid, input opcode, input mem_address,
                   input mem_data, output ready);
endinterface

interface sm83_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  run_state;
   logic [7:0]  read_byte;
   logic [15:0] pc_value;
   logic [7:0]  acc_value;
   logic [3:0]  flag_value;
   logic [15:0] bc_value;
   logic [15:0] de_value;
   logic [15:0] hl_value;
   logic [15:0] sp_value;
   logic [31:0] cycle_value;

   modport source (output valid, output run_state, output read_byte, output pc_value,
                   output acc_value, output flag_value, output bc_value,
                   output de_value, output hl_value, output sp_value,
                   output cycle_value, input ready);
   modport sink   (input valid, input run_state, input read_byte, input pc_value,
                   input acc_value, input flag_value, input bc_value,
                   input de_value, input hl_value, input sp_value,
                   input cycle_value, output ready);
endinterface

// ===== rtl/sm83_ram.sv =====
// ============================================================================
// sm83_ram: generic single-port RAM
// One access per cycle; a read returns its data registered on the next cycle.
// ============================================================================
module sm83_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/sm83_seq.sv =====
// ============================================================================
// sm83_seq: microcode sequencer
// Holds the micro program counter, reads the control word for the current
// step and works out the next step from jumps and opcode dispatch.
// ============================================================================
module sm83_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_kind,
   input  logic                   running,
   input  logic                   rsp_free,
   input  logic [7:0]             ram_rdata,
   output logic                   req_ready,
   output sm83_pkg::seq_ctrl_type ctrl
);

   logic [sm83_pkg::UPC_BITS-1:0] upc_ff;
   logic [sm83_pkg::UPC_BITS-1:0] upc_in;
   sm83_pkg::ucw_type             uw;
   logic [sm83_pkg::UPC_BITS-1:0] item_entry;

   assign uw = sm83_pkg::ucode(upc_ff);

   always_comb begin
      case (req_kind)
         sm83_pkg::KIND_WRITE: item_entry = sm83_pkg::U_WR;
         sm83_pkg::KIND_READ:  item_entry = sm83_pkg::U_RD;
         sm83_pkg::KIND_EXEC:  item_entry = running ? sm83_pkg::U_FETCH
                                                    : sm83_pkg::U_DONE;
         default:              item_entry = sm83_pkg::U_DONE;
      endcase
   end

   always_comb begin
      case (uw.seq)
         sm83_pkg::SEQ_NEXT:   upc_in = upc_ff + sm83_pkg::UPC_BITS'(1);
         sm83_pkg::SEQ_JUMP:   upc_in = uw.target;
         sm83_pkg::SEQ_DECODE: upc_in = sm83_pkg::decode_op(ram_rdata);
         sm83_pkg::SEQ_CBSEL:  upc_in = sm83_pkg::cb_entry(ram_rdata);
         sm83_pkg::SEQ_IDLE:   upc_in = req_valid ? item_entry : upc_ff;
         sm83_pkg::SEQ_DONE:   upc_in = rsp_free ? sm83_pkg::U_IDLE : upc_ff;
         default:              upc_in = sm83_pkg::U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= sm83_pkg::U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign req_ready  = (uw.seq == sm83_pkg::SEQ_IDLE);
   assign ctrl.uw    = uw;
   assign ctrl.start = (uw.seq == sm83_pkg::SEQ_IDLE) && req_valid;
   assign ctrl.load  = (uw.seq == sm83_pkg::SEQ_DONE) && rsp_free;

endmodule

// ===== rtl/sm83_dp.sv =====
// ============================================================================
// sm83_dp: core datapath
// Register file, flags, cycle counter and memory port steering, all driven
// by the control word of the current microcode step.
// ============================================================================
module sm83_dp #(
   parameter int ADDR_BITS = sm83_pkg::ADDR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sm83_pkg::seq_ctrl_type ctrl,
   input  logic [15:0]            req_address,
   input  logic [7:0]             req_data,
   input  logic [7:0]             ram_rdata,
   output logic                   ram_en,
   output logic                   ram_we,
   output logic [ADDR_BITS-1:0]   ram_addr,
   output logic [7:0]             ram_wdata,
   output sm83_pkg::arch_type     arch
);

   // 8-bit register indexes as encoded in the opcodes.
   localparam logic [2:0] R8_B = 3'd0;
   localparam logic [2:0] R8_C = 3'd1;
   localparam logic [2:0] R8_D = 3'd2;
   localparam logic [2:0] R8_E = 3'd3;
   localparam logic [2:0] R8_H = 3'd4;
   localparam logic [2:0] R8_L = 3'd5;
   localparam logic [2:0] R8_A = 3'd7;

   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;

   sm83_pkg::ucw_type uw;

   logic [15:0] pc_ff, pc_in;
   logic [7:0]  acc_ff, acc_in;
   logic [3:0]  flag_ff, flag_in;
   logic [15:0] bc_ff, bc_in;
   logic [15:0] de_ff, de_in;
   logic [15:0] hl_ff, hl_in;
   logic [15:0] sp_ff, sp_in;
   logic [31:0] cycle_ff, cycle_in;
   logic [1:0]  stop_ff, stop_in;

   logic [15:0] item_addr_ff;
   logic [7:0]  item_data_ff;
   logic [7:0]  op_ff;
   logic [7:0]  cb_ff;
   logic [7:0]  lo_ff;
   logic [7:0]  rd_byte_ff;

   logic [2:0]  opnd_idx;
   logic [7:0]  opnd;
   logic [7:0]  xor_res;
   logic        jr_flag;
   logic        jr_take;
   logic [4:0]  cyc_amt;
   logic [15:0] addr_full;

   assign uw = ctrl.uw;

   // Operand index 6 is the memory byte at HL, already read into the RAM output.
   always_comb begin
      opnd_idx = (uw.op == sm83_pkg::DP_BIT) ? cb_ff[2:0] : op_ff[2:0];
      case (opnd_idx)
         R8_B:                opnd = bc_ff[15:8];
         R8_C:                opnd = bc_ff[7:0];
         R8_D:                opnd = de_ff[15:8];
         R8_E:                opnd = de_ff[7:0];
         R8_H:                opnd = hl_ff[15:8];
         R8_L:                opnd = hl_ff[7:0];
         sm83_pkg::SRC_MEM:   opnd = ram_rdata;
         default:             opnd = acc_ff;
      endcase
   end

   assign xor_res = acc_ff ^ opnd;

   // Unconditional JR has bit 5 clear; otherwise bit 4 picks C or Z and bit 3
   // gives the level that takes the branch.
   assign jr_flag = op_ff[4] ? flag_ff[sm83_pkg::FLAG_C_BIT]
                             : flag_ff[sm83_pkg::FLAG_Z_BIT];
   assign jr_take = !op_ff[5] || (jr_flag == op_ff[3]);

   always_comb begin
      case (uw.cyc)
         sm83_pkg::CYC_4:  cyc_amt = 5'd4;
         sm83_pkg::CYC_8:  cyc_amt = 5'd8;
         sm83_pkg::CYC_12: cyc_amt = 5'd12;
         sm83_pkg::CYC_16: cyc_amt = 5'd16;
         sm83_pkg::CYC_JR: cyc_amt = jr_take ? 5'd12 : 5'd8;
         default:          cyc_amt = 5'd0;
      endcase
   end

   always_comb begin
      pc_in    = pc_ff;
      acc_in   = acc_ff;
      flag_in  = flag_ff;
      bc_in    = bc_ff;
      de_in    = de_ff;
      hl_in    = hl_ff;
      sp_in    = sp_ff;
      stop_in  = stop_ff;
      cycle_in = cycle_ff + 32'(cyc_amt);
      if (uw.pc_inc) begin
         pc_in = pc_ff + 16'd1;
      end
      case (uw.op)
         sm83_pkg::DP_JR: begin
            if (jr_take) begin
               pc_in = pc_ff + {{8{ram_rdata[7]}}, ram_rdata};
            end
         end
         sm83_pkg::DP_LD_PAIR: begin
            case (op_ff[5:4])
               PAIR_BC: bc_in = {ram_rdata, lo_ff};
               PAIR_DE: de_in = {ram_rdata, lo_ff};
               PAIR_HL: hl_in = {ram_rdata, lo_ff};
               default: sp_in = {ram_rdata, lo_ff};
            endcase
         end
         sm83_pkg::DP_XOR: begin
            acc_in  = xor_res;
            flag_in = '0;
            flag_in[sm83_pkg::FLAG_Z_BIT] = (xor_res == 8'd0);
         end
         sm83_pkg::DP_LD_R8: begin
            case (op_ff[5:3])
               R8_B:    bc_in[15:8] = ram_rdata;
               R8_C:    bc_in[7:0]  = ram_rdata;
               R8_D:    de_in[15:8] = ram_rdata;
               R8_E:    de_in[7:0]  = ram_rdata;
               R8_H:    hl_in[15:8] = ram_rdata;
               R8_L:    hl_in[7:0]  = ram_rdata;
               R8_A:    acc_in      = ram_rdata;
               default: acc_in      = acc_ff;
            endcase
         end
         sm83_pkg::DP_BIT: begin
            flag_in[sm83_pkg::FLAG_Z_BIT] = !opnd[cb_ff[5:3]];
            flag_in[sm83_pkg::FLAG_N_BIT] = 1'b0;
            flag_in[sm83_pkg::FLAG_H_BIT] = 1'b1;
         end
         sm83_pkg::DP_HL_INC: hl_in   = hl_ff + 16'd1;
         sm83_pkg::DP_HL_DEC: hl_in   = hl_ff - 16'd1;
         sm83_pkg::DP_HALT:   stop_in = sm83_pkg::RUN_HALT;
         sm83_pkg::DP_BAD:    stop_in = sm83_pkg::RUN_BAD;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= '0;
         acc_ff   <= '0;
         flag_ff  <= '0;
         bc_ff    <= '0;
         de_ff    <= '0;
         hl_ff    <= '0;
         sp_ff    <= '0;
         cycle_ff <= '0;
         stop_ff  <= sm83_pkg::RUN_OK;
      end else begin
         pc_ff    <= pc_in;
         acc_ff   <= acc_in;
         flag_ff  <= flag_in;
         bc_ff    <= bc_in;
         de_ff    <= de_in;
         hl_ff    <= hl_in;
         sp_ff    <= sp_in;
         cycle_ff <= cycle_in;
         stop_ff  <= stop_in;
      end
   end

   // Item payload and instruction byte latches.
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         item_addr_ff <= req_address;
         item_data_ff <= req_data;
         rd_byte_ff   <= 8'd0;
      end else if (uw.op == sm83_pkg::DP_READ) begin
         rd_byte_ff <= ram_rdata;
      end
      if (uw.op == sm83_pkg::DP_LATCH_OP) begin
         op_ff <= ram_rdata;
      end
      if (uw.op == sm83_pkg::DP_LATCH_CB) begin
         cb_ff <= ram_rdata;
      end
      if (uw.op == sm83_pkg::DP_LATCH_LO) begin
         lo_ff <= ram_rdata;
      end
   end

   always_comb begin
      case (uw.asel)
         sm83_pkg::ASEL_HL:   addr_full = hl_ff;
         sm83_pkg::ASEL_BC:   addr_full = bc_ff;
         sm83_pkg::ASEL_DE:   addr_full = de_ff;
         sm83_pkg::ASEL_ITEM: addr_full = item_addr_ff;
         default:             addr_full = pc_ff;
      endcase
      case (uw.wsel)
         sm83_pkg::WSEL_ITEM:  ram_wdata = item_data_ff;
         sm83_pkg::WSEL_RDATA: ram_wdata = ram_rdata;
         default:              ram_wdata = acc_ff;
      endcase
   end

   assign ram_en   = uw.mem_en;
   assign ram_we   = uw.mem_we;
   assign ram_addr = addr_full[ADDR_BITS-1:0];

   assign arch.run_state   = stop_ff;
   assign arch.read_byte   = rd_byte_ff;
   assign arch.pc_value    = pc_ff;
   assign arch.acc_value   = acc_ff;
   assign arch.flag_value  = flag_ff;
   assign arch.bc_value    = bc_ff;
   assign arch.de_value    = de_ff;
   assign arch.hl_value    = hl_ff;
   assign arch.sp_value    = sp_ff;
   assign arch.cycle_value = cycle_ff;

endmodule

// ===== rtl/cpu_core_instruction_subset_unit.sv =====
// ============================================================================
// cpu_core_instruction_subset_unit: microcoded 8-bit core with local memory
// Executes a subset of the instruction set out of 2^ADDR_BITS bytes of RAM.
// ============================================================================
// Usage:
//   req_bus carries one item per beat: opcode selects a memory byte write,
//   a memory byte read, or the execution of one instruction at the PC.
//   rsp_bus returns exactly one beat per item with the run status, the byte
//   read (zero for other items) and the full register state afterwards.
//   Each item walks a short microcode routine, one memory access per step on
//   the single-port RAM. An execute item while the core is stopped goes
//   straight to its final step.
//   One item is in flight at a time; req_bus.ready is high while the
//   sequencer sits in its idle step.
//   The result register frees the sequencer: a new item is accepted while
//   a result still waits, and that item holds in its final step until the
//   receiver takes the older beat.
//   Synchronous reset clears the registers, the cycle count and the run
//   status, and empties the result register. RAM contents are not cleared.
// ============================================================================
module cpu_core_instruction_subset_unit #(
   parameter int ADDR_BITS = sm83_pkg::ADDR_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   sm83_req_if.sink    req_bus,
   sm83_rsp_if.source  rsp_bus
);

   sm83_pkg::seq_ctrl_type ctrl;
   sm83_pkg::arch_type     arch;
   sm83_pkg::arch_type     rsp_pay_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_free;
   logic                   req_ready_w;
   logic                   ram_en;
   logic                   ram_we;
   logic [ADDR_BITS-1:0]   ram_addr;
   logic [7:0]             ram_wdata;
   logic [7:0]             ram_rdata;

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   sm83_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_kind  (req_bus.opcode),
      .running   (arch.run_state == sm83_pkg::RUN_OK),
      .rsp_free  (rsp_free),
      .ram_rdata (ram_rdata),
      .req_ready (req_ready_w),
      .ctrl      (ctrl)
   );

   sm83_dp #(
      .ADDR_BITS (ADDR_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .req_address (req_bus.mem_address),
      .req_data    (req_bus.mem_data),
      .ram_rdata   (ram_rdata),
      .ram_en      (ram_en),
      .ram_we      (ram_we),
      .ram_addr    (ram_addr),
      .ram_wdata   (ram_wdata),
      .arch        (arch)
   );

   sm83_ram #(
      .WIDTH (8),
      .DEPTH (1 << ADDR_BITS)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign req_bus.ready = req_ready_w;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rsp_pay_ff <= arch;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.run_state   = rsp_pay_ff.run_state;
   assign rsp_bus.read_byte   = rsp_pay_ff.read_byte;
   assign rsp_bus.pc_value    = rsp_pay_ff.pc_value;
   assign rsp_bus.acc_value   = rsp_pay_ff.acc_value;
   assign rsp_bus.flag_value  = rsp_pay_ff.flag_value;
   assign rsp_bus.bc_value    = rsp_pay_ff.bc_value;
   assign rsp_bus.de_value    = rsp_pay_ff.de_value;
   assign rsp_bus.hl_value    = rsp_pay_ff.hl_value;
   assign rsp_bus.sp_value    = rsp_pay_ff.sp_value;
   assign rsp_bus.cycle_value = rsp_pay_ff.cycle_value;

`ifndef SYNTH
   // Once stopped, only reset brings the core back to running.
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      (arch.run_state != sm83_pkg::RUN_OK) |=> (arch.run_state != sm83_pkg::RUN_OK))
      else $error("run status returned to running without reset");

   // Nothing architectural moves while the sequencer waits for an item.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready_w |=> ($stable(arch.cycle_value) && $stable(arch.pc_value)))
      else $error("PC or cycle count changed in the idle step");

   // A result is only loaded into a free slot, so no beat is overwritten.
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |-> !(rsp_valid_ff && !rsp_bus.ready))
      else $error("result loaded over a beat still waiting");
`endif

endmodule

// ===== test/cpu_core_instruction_subset_unit_tb.sv =====
// ============================================================================
// cpu_core_instruction_subset_unit_tb: self-checking bench for the 8-bit core
// Drives write, read and execute beats into the core and predicts the full
// architectural state after each one. Code bytes and any byte read through
// HL are written before use, so no unwritten RAM byte is ever fetched or read.
// Both channels stall at random, with one long stretch running flat out.
// ============================================================================
module cpu_core_instruction_subset_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sm83_pkg::*;

   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Operand field of XOR r and BIT b,r.
   localparam logic [2:0] SRC_B = 3'd0;
   localparam logic [2:0] SRC_C = 3'd1;
   localparam logic [2:0] SRC_D = 3'd2;
   localparam logic [2:0] SRC_E = 3'd3;
   localparam logic [2:0] SRC_H = 3'd4;
   localparam logic [2:0] SRC_L = 3'd5;
   localparam logic [2:0] SRC_A = 3'd7;

   // Opcodes this core does not implement.
   localparam logic [7:0] OPC_NOP_UNSUPPORTED  = 8'h00;
   localparam logic [7:0] OPC_RST38_UNSUPPORTED = 8'hFF;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int ITEM_TARGET  = 930;
   localparam int DRAIN_CYCLES = 20;

   class core_result_checker;
      logic [7:0]  mem_image [65536];
      bit          written [65536];
      logic [15:0] written_addrs [$];
      logic [15:0] pc, bc, de, hl, sp;
      logic [7:0]  acc;
      logic [3:0]  flags;
      logic [31:0] cycles;
      logic [1:0]  status;
      arch_type    predicted_states [$];
      int          failures;

      function new();
         pc = '0; bc = '0; de = '0; hl = '0; sp = '0;
         acc = '0; flags = '0; cycles = '0; status = RUN_OK;
         failures = 0;
         foreach (written[i]) written[i] = 1'b0;
      endfunction

      function int pending();
         return predicted_states.size();
      endfunction

      function void store_byte(logic [15:0] addr, logic [7:0] value);
         mem_image[addr] = value;
         if (!written[addr]) begin
            written[addr] = 1'b1;
            written_addrs.push_back(addr);
         end
      endfunction

      function logic [7:0] fetch_code_byte();
         logic [7:0] value;
         value = mem_image[pc];
         pc = pc + 16'd1;
         return value;
      endfunction

      function logic [7:0] operand(logic [2:0] src);
         case (src)
            SRC_B:   return bc[15:8];
            SRC_C:   return bc[7:0];
            SRC_D:   return de[15:8];
            SRC_E:   return de[7:0];
            SRC_H:   return hl[15:8];
            SRC_L:   return hl[7:0];
            SRC_MEM: return mem_image[hl];
            default: return acc;
         endcase
      endfunction

      function void jump_rel(bit take);
         logic [7:0] offset;
         offset = fetch_code_byte();
         if (take) begin
            pc = pc + {{8{offset[7]}}, offset};
            cycles = cycles + 32'd12;
         end else begin
            cycles = cycles + 32'd8;
         end
      endfunction

      function void exec_instruction();
         logic [7:0]  op, lo, hi, code, value;
         logic [15:0] word;
         logic [3:0]  nf;
         op = fetch_code_byte();
         case (op)
            OPC_JR:    jump_rel(1'b1);
            OPC_JR_NZ: jump_rel(!flags[FLAG_Z_BIT]);
            OPC_JR_Z:  jump_rel(flags[FLAG_Z_BIT]);
            OPC_JR_NC: jump_rel(!flags[FLAG_C_BIT]);
            OPC_JR_C:  jump_rel(flags[FLAG_C_BIT]);
            OPC_LD_BC, OPC_LD_DE, OPC_LD_HL, OPC_LD_SP: begin
               lo = fetch_code_byte();
               hi = fetch_code_byte();
               word = {hi, lo};
               if (op == OPC_LD_BC) bc = word;
               else if (op == OPC_LD_DE) de = word;
               else if (op == OPC_LD_HL) hl = word;
               else sp = word;
               cycles = cycles + 32'd12;
            end
            OPC_ST_BC: begin
               store_byte(bc, acc);
               cycles = cycles + 32'd8;
            end
            OPC_ST_DE: begin
               store_byte(de, acc);
               cycles = cycles + 32'd8;
            end
            OPC_ST_HLI: begin
               store_byte(hl, acc);
               hl = hl + 16'd1;
               cycles = cycles + 32'd8;
            end
            OPC_ST_HLD: begin
               store_byte(hl, acc);
               hl = hl - 16'd1;
               cycles = cycles + 32'd8;
            end
            OPC_LD_B_D8: begin bc[15:8] = fetch_code_byte(); cycles = cycles + 32'd8; end
            OPC_LD_C_D8: begin bc[7:0]  = fetch_code_byte(); cycles = cycles + 32'd8; end
            OPC_LD_D_D8: begin de[15:8] = fetch_code_byte(); cycles = cycles + 32'd8; end
            OPC_LD_E_D8: begin de[7:0]  = fetch_code_byte(); cycles = cycles + 32'd8; end
            OPC_LD_H_D8: begin hl[15:8] = fetch_code_byte(); cycles = cycles + 32'd8; end
            OPC_LD_L_D8: begin hl[7:0]  = fetch_code_byte(); cycles = cycles + 32'd8; end
            OPC_LD_A_D8: begin acc      = fetch_code_byte(); cycles = cycles + 32'd8; end
            OPC_LD_M_D8: begin
               lo = fetch_code_byte();
               store_byte(hl, lo);
               cycles = cycles + 32'd12;
            end
            OPC_PREFIX: begin
               code = fetch_code_byte();
               cycles = cycles + 32'd8;
               // Only BIT b,r does anything; every other prefixed code is a no-op.
               if (code >= CB_BIT_FIRST && code <= CB_BIT_LAST) begin
                  value = operand(code[2:0]);
                  nf = '0;
                  nf[FLAG_Z_BIT] = ~value[code[5:3]];
                  nf[FLAG_H_BIT] = 1'b1;
                  nf[FLAG_C_BIT] = flags[FLAG_C_BIT];
                  flags = nf;
                  if (code[2:0] == SRC_MEM) cycles = cycles + 32'd8;
               end
            end
            OPC_HALT: begin
               cycles = cycles + 32'd4;
               status = RUN_HALT;
            end
            default: begin
               if (op >= OPC_XOR_B && op <= OPC_XOR_A) begin
                  acc = acc ^ operand(op[2:0]);
                  nf = '0;
                  nf[FLAG_Z_BIT] = (acc == 8'h00);
                  flags = nf;
                  cycles = cycles + ((op == OPC_XOR_M) ? 32'd8 : 32'd4);
               end else begin
                  status = RUN_BAD;
               end
            end
         endcase
      endfunction

      // Called once per accepted request beat.
      function void note_item(logic [1:0] kind, logic [15:0] addr, logic [7:0] data);
         arch_type   state;
         logic [7:0] rd;
         rd = 8'h00;
         if (kind == KIND_WRITE) store_byte(addr, data);
         else if (kind == KIND_READ) rd = mem_image[addr];
         else if (kind == KIND_EXEC && status == RUN_OK) exec_instruction();
         state = '{status, rd, pc, acc, flags, bc, de, hl, sp, cycles};
         predicted_states.push_back(state);
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            failures++;
            if (failures <= 10)
               $display("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         end
      endfunction

      function void check_state(arch_type got);
         arch_type want;
         if (predicted_states.size() == 0) begin
            failures++;
            if (failures <= 10) $display("result beat with no prediction waiting");
            return;
         end
         want = predicted_states.pop_front();
         compare_field("run_state", want.run_state, got.run_state);
         compare_field("read_byte", want.read_byte, got.read_byte);
         compare_field("pc_value", want.pc_value, got.pc_value);
         compare_field("acc_value", want.acc_value, got.acc_value);
         compare_field("flag_value", want.flag_value, got.flag_value);
         compare_field("bc_value", want.bc_value, got.bc_value);
         compare_field("de_value", want.de_value, got.de_value);
         compare_field("hl_value", want.hl_value, got.hl_value);
         compare_field("sp_value", want.sp_value, got.sp_value);
         compare_field("cycle_value", want.cycle_value, got.cycle_value);
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   steady;
   int   items_sent;
   int   clock_ticks;
   core_result_checker sb;

   sm83_req_if req_bus ();
   sm83_rsp_if rsp_bus ();

   cpu_core_instruction_subset_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Sends one request beat and notes it once it is accepted. Valid is left
   // high so that a following beat can go out on the very next edge.
   task automatic send_item(input logic [1:0] kind, input logic [15:0] addr,
                            input logic [7:0] data);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode      <= kind;
      req_bus.mem_address <= addr;
      req_bus.mem_data    <= data;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_item(kind, addr, data);
      items_sent++;
   endtask

   // Places one instruction at the PC, plus the byte at HL when it reads one
   // not yet written, and then executes it.
   task automatic run_code(input logic [7:0] op, input logic [7:0] b1,
                           input logic [7:0] b2, input int len);
      bit reads_hl;
      reads_hl = (op == OPC_XOR_M) ||
                 (op == OPC_PREFIX && b1 >= CB_BIT_FIRST && b1 <= CB_BIT_LAST &&
                  b1[2:0] == SRC_MEM);
      if (reads_hl && !sb.written[sb.hl]) send_item(KIND_WRITE, sb.hl, 8'($urandom));
      send_item(KIND_WRITE, sb.pc, op);
      if (len > 1) send_item(KIND_WRITE, sb.pc + 16'd1, b1);
      if (len > 2) send_item(KIND_WRITE, sb.pc + 16'd2, b2);
      send_item(KIND_EXEC, 16'($urandom), 8'($urandom));
   endtask

   task automatic issue_instr();
      logic [7:0] op, b1, b2;
      int         pick, len;
      pick = $urandom_range(0, 99);
      b1 = 8'($urandom);
      b2 = 8'($urandom);
      if (pick < 20) begin
         case ($urandom_range(0, 4))
            0: op = OPC_JR;
            1: op = OPC_JR_NZ;
            2: op = OPC_JR_Z;
            3: op = OPC_JR_NC;
            default: op = OPC_JR_C;
         endcase
         len = 2;
      end else if (pick < 32) begin
         case ($urandom_range(0, 3))
            0: op = OPC_LD_BC;
            1: op = OPC_LD_DE;
            2: op = OPC_LD_HL;
            default: op = OPC_LD_SP;
         endcase
         len = 3;
      end else if (pick < 50) begin
         op = OPC_XOR_B + 8'($urandom_range(0, 7));
         len = 1;
      end else if (pick < 62) begin
         case ($urandom_range(0, 3))
            0: op = OPC_ST_BC;
            1: op = OPC_ST_DE;
            2: op = OPC_ST_HLI;
            default: op = OPC_ST_HLD;
         endcase
         len = 1;
      end else if (pick < 80) begin
         case ($urandom_range(0, 7))
            0: op = OPC_LD_B_D8;
            1: op = OPC_LD_C_D8;
            2: op = OPC_LD_D_D8;
            3: op = OPC_LD_E_D8;
            4: op = OPC_LD_H_D8;
            5: op = OPC_LD_L_D8;
            6: op = OPC_LD_A_D8;
            default: op = OPC_LD_M_D8;
         endcase
         len = 2;
      end else begin
         op = OPC_PREFIX;
         if ($urandom_range(0, 3) != 0) b1 = CB_BIT_FIRST + 8'($urandom_range(0, 63));
         len = 2;
      end
      run_code(op, b1, b2, len);
   endtask

   initial begin
      clock_ticks = 0;
      while (clock_ticks <= CYCLE_LIMIT) begin
         @(posedge clock);
         clock_ticks++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      arch_type got;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.run_state, rsp_bus.read_byte, rsp_bus.pc_value,
                    rsp_bus.acc_value, rsp_bus.flag_value, rsp_bus.bc_value,
                    rsp_bus.de_value, rsp_bus.hl_value, rsp_bus.sp_value,
                    rsp_bus.cycle_value};
            sb.check_state(got);
         end
         rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 34);
      end
   end

   initial begin
      bit         drained;
      int         pick;
      logic [7:0] stop_op;
      req_bus.valid       = 1'b0;
      req_bus.opcode      = KIND_WRITE;
      req_bus.mem_address = '0;
      req_bus.mem_data    = '0;
      reset = 1'b1;
      steady = 1'b0;
      drained = 1'b0;
      items_sent = 0;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Field extremes, the unused item kind, HL wrapping both ways, memory
      // operands and the largest jumps in each direction.
      send_item(KIND_WRITE, 16'hFFFF, 8'hFF);
      send_item(KIND_WRITE, 16'h0000, 8'h00);
      send_item(KIND_READ, 16'hFFFF, 8'h00);
      send_item(KIND_READ, 16'h0000, 8'hFF);
      send_item(KIND_SPARE, 16'hFFFF, 8'hFF);
      run_code(OPC_LD_HL, 8'hFF, 8'hFF, 3);
      run_code(OPC_LD_A_D8, 8'h80, 8'h00, 2);
      run_code(OPC_ST_HLI, 8'h00, 8'h00, 1);
      run_code(OPC_ST_HLD, 8'h00, 8'h00, 1);
      run_code(OPC_XOR_M, 8'h00, 8'h00, 1);
      run_code(OPC_PREFIX, 8'h7E, 8'h00, 2);
      run_code(OPC_JR, 8'h80, 8'h00, 2);
      run_code(OPC_JR, 8'h7F, 8'h00, 2);

      while (items_sent < ITEM_TARGET) begin
         steady = (items_sent >= 250 && items_sent < 420);
         if (!drained && items_sent >= 500) begin
            // Let the core run completely dry once before carrying on.
            req_bus.valid <= 1'b0;
            @(posedge clock);
            while (sb.pending() != 0) @(posedge clock);
            drained = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 62) issue_instr();
         else if (pick < 76) send_item(KIND_WRITE, 16'($urandom), 8'($urandom));
         else if (pick < 94)
            send_item(KIND_READ, sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)],
                      8'($urandom));
         else send_item(KIND_SPARE, 16'($urandom), 8'($urandom));
      end
      steady = 1'b0;

      // The core can stop only once per run, so the stop comes last.
      case ($urandom_range(0, 2))
         0: stop_op = OPC_HALT;
         1: stop_op = OPC_NOP_UNSUPPORTED;
         default: stop_op = OPC_RST38_UNSUPPORTED;
      endcase
      run_code(stop_op, 8'h00, 8'h00, 1);
      repeat (3) send_item(KIND_EXEC, 16'($urandom), 8'($urandom));
      send_item(KIND_WRITE, 16'($urandom), 8'($urandom));
      send_item(KIND_READ, sb.written_addrs[$urandom_range(0, sb.written_addrs.size() - 1)],
                8'h00);
      send_item(KIND_SPARE, 16'($urandom), 8'($urandom));
      run_code(OPC_LD_A_D8, 8'h5A, 8'h00, 2);

      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.failures += sb.pending();
      if (sb.failures == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
